[rtl/hsvd_pkg.sv]
// hsvd_pkg: shared types and constants for the HSV dominant color detector.
// Used by the top, front and back modules and the testbench; depends on nothing.
`default_nettype none

package hsvd_pkg;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int HIT_W    = 22;
    localparam int THRESH_W = 8;

    // Counter width default and queue depth
    localparam int COUNT_BITS_DEF = 22;
    localparam int QUEUE_DEPTH    = 4;

    // Divider: quotient bits, one per pipeline stage
    localparam int DIV_STAGES = 8;
    localparam int HNUM_W     = 17;
    localparam int HDEN_W     = 9;
    localparam int SNUM_W     = 16;
    localparam int SDEN_W     = 8;

    // HSV scaling
    localparam logic [HNUM_W-1:0] HUE_SCALE  = 17'd60;
    localparam logic [SNUM_W-1:0] FULL_SCALE = 16'd255;
    localparam logic [7:0]        HUE_OFFSET = 8'd30;
    localparam logic [7:0]        HUE_WRAP   = 8'd150;

    // Color windows (inclusive); red hue starts at zero
    localparam logic [7:0] RED_H_HI   = 8'd10;
    localparam logic [7:0] GREEN_H_LO = 8'd40;
    localparam logic [7:0] GREEN_H_HI = 8'd80;
    localparam logic [7:0] BLUE_H_LO  = 8'd85;
    localparam logic [7:0] BLUE_H_HI  = 8'd135;
    localparam logic [7:0] RG_S_LO    = 8'd70;
    localparam logic [7:0] RG_V_LO    = 8'd50;
    localparam logic [7:0] BLUE_S_LO  = 8'd50;
    localparam logic [7:0] BLUE_V_LO  = 8'd40;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd15;

    typedef enum logic [1:0] {
        COLOR_RED   = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_BLUE  = 2'd2,
        COLOR_NONE  = 2'd3
    } color_class_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } pixel_t;

    typedef struct packed {
        color_class_t     color_class;
        logic [HIT_W-1:0] red_hits;
        logic [HIT_W-1:0] green_hits;
        logic [HIT_W-1:0] blue_hits;
    } result_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic frame_end;
        logic red;
        logic green;
        logic blue;
    } hit_t;

endpackage

`default_nettype wire

[rtl/hsv_dominant_color_detect.sv]
// hsv_dominant_color_detect: top level of the dominant color detector.
// Depends on hsvd_pkg, hsvd_front, hsvd_fifo and hsvd_back.
//
//   channel   ports                       transaction
//   pixel     push, full, pixel           push && !full
//   result    pop, empty, result          pop && !empty
//   config    cfg_we, cfg_wdata           cfg_we
//
// One pixel per clock sustained unless the output stalls; the two 8-stage
// pipelined dividers of the front keep that rate. A pixel passes front stages
// A, B, the divider stages and C, then the queue, counters, decision stage and
// result register. Reset clears the counters, the queue and all valid flags and
// sets the threshold to 15. A blocked result register stalls the decision stage,
// then the queue once a frame end heads it, then the front pipeline as a whole.
`default_nettype none

module hsv_dominant_color_detect #(
    parameter int COUNT_BITS = hsvd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire hsvd_pkg::pixel_t              pixel,
    input  wire logic                          pop,
    output logic                               empty,
    output hsvd_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire logic [hsvd_pkg::THRESH_W-1:0] cfg_wdata
);

    hsvd_pkg::hit_t front_hits;
    hsvd_pkg::hit_t q_hits;
    logic           q_push, q_full, q_pop, q_empty;

    hsvd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .pixel  (pixel),
        .q_push (q_push),
        .q_data (front_hits),
        .q_full (q_full)
    );

    hsvd_fifo #(
        .WIDTH ($bits(hsvd_pkg::hit_t)),
        .DEPTH (hsvd_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (front_hits),
        .wr_full  (q_full),
        .rd_en    (q_pop),
        .rd_data  (q_hits),
        .rd_empty (q_empty)
    );

    hsvd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_data    (q_hits),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

[rtl/hsvd_div.sv]
// hsvd_div: pipelined restoring divider, one quotient bit per stage.
// Uses no package items; quotient must fit in QUO_W bits.
`default_nettype none

module hsvd_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 9,
    parameter int QUO_W = 8
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int CW = NUM_W + DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CW-1:0]    shifted;
        logic [CW-1:0]    rem_ext;
        logic             fits;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // trial subtract of the divisor at this bit weight
        assign shifted = CW'(den_in) << (QUO_W - 1 - k);
        assign rem_ext = CW'(rem_in);
        assign fits    = (rem_ext >= shifted);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_in | (fits ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fits ? NUM_W'(rem_ext - shifted) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

[rtl/hsvd_front.sv]
// hsvd_front: pixel intake, RGB to HSV conversion and window classification.
// Depends on hsvd_pkg and hsvd_div.
`default_nettype none

module hsvd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire hsvd_pkg::pixel_t pixel,
    output logic                 q_push,
    output hsvd_pkg::hit_t       q_data,
    input  wire logic            q_full
);

    localparam int NS = hsvd_pkg::DIV_STAGES;

    typedef struct packed {
        logic [7:0] v;
        logic       d_zero;
        logic       frame_end;
    } side_t;

    logic adv;

    // stage A: input register
    logic             valid_a_reg;
    hsvd_pkg::pixel_t pix_a_reg;

    // stage B: max, spread, hue numerator
    logic        valid_b_reg;
    logic [7:0]  v_b_reg;
    logic [7:0]  d_b_reg;
    logic [10:0] hh_b_reg;
    logic        fe_b_reg;

    logic [7:0]  v_a;
    logic [7:0]  mn_a;
    logic [7:0]  d_a;
    logic [10:0] hh_a;

    // divider stages
    logic [NS-1:0] vld_reg;
    side_t         side_reg [NS];
    logic [7:0]    h_quo;
    logic [7:0]    s_quo;
    logic [hsvd_pkg::HNUM_W-1:0] h_num;
    logic [hsvd_pkg::HDEN_W-1:0] h_den;
    logic [hsvd_pkg::SNUM_W-1:0] s_num;
    logic [hsvd_pkg::SDEN_W-1:0] s_den;

    // stage C: classified hits
    logic           valid_c_reg;
    hsvd_pkg::hit_t hits_c_reg;
    hsvd_pkg::hit_t hits;
    logic [7:0]     hue;
    logic [7:0]     sat;
    logic [7:0]     val;

    // whole pipeline moves together unless the last stage is blocked
    assign adv  = !valid_c_reg || !q_full;
    assign full = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            vld_reg     <= '0;
            valid_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= push;
            valid_b_reg <= valid_a_reg;
            vld_reg     <= {vld_reg[NS-2:0], valid_b_reg};
            valid_c_reg <= vld_reg[NS-1];
        end
    end

    // max, min and sector numerator; ties go red, then green
    always_comb
    begin
        v_a  = pix_a_reg.red;
        mn_a = pix_a_reg.red;
        if (pix_a_reg.green > v_a)
        begin
            v_a = pix_a_reg.green;
        end
        if (pix_a_reg.blue > v_a)
        begin
            v_a = pix_a_reg.blue;
        end
        if (pix_a_reg.green < mn_a)
        begin
            mn_a = pix_a_reg.green;
        end
        if (pix_a_reg.blue < mn_a)
        begin
            mn_a = pix_a_reg.blue;
        end
        d_a = v_a - mn_a;
        if (v_a == pix_a_reg.red)
        begin
            hh_a = 11'(pix_a_reg.green) + 11'(d_a) - 11'(pix_a_reg.blue);
        end
        else if (v_a == pix_a_reg.green)
        begin
            hh_a = 11'(pix_a_reg.blue) + 11'(d_a) * 11'd3 - 11'(pix_a_reg.red);
        end
        else
        begin
            hh_a = 11'(pix_a_reg.red) + 11'(d_a) * 11'd5 - 11'(pix_a_reg.green);
        end
    end

    // payload registers of stages A and B
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_a_reg <= pixel;
            v_b_reg   <= v_a;
            d_b_reg   <= d_a;
            hh_b_reg  <= hh_a;
            fe_b_reg  <= pix_a_reg.frame_end;
        end
    end

    // divider operands: rounded hue/2 and rounded saturation
    assign h_num = hsvd_pkg::HNUM_W'(hh_b_reg) * hsvd_pkg::HUE_SCALE
                 + hsvd_pkg::HNUM_W'(d_b_reg);
    assign h_den = {d_b_reg, 1'b0};
    assign s_num = hsvd_pkg::SNUM_W'(d_b_reg) * hsvd_pkg::FULL_SCALE
                 + hsvd_pkg::SNUM_W'(v_b_reg >> 1);
    assign s_den = v_b_reg;

    hsvd_div #(
        .NUM_W (hsvd_pkg::HNUM_W),
        .DEN_W (hsvd_pkg::HDEN_W),
        .QUO_W (NS)
    ) u_hdiv (
        .clk (clk),
        .en  (adv),
        .num (h_num),
        .den (h_den),
        .quo (h_quo)
    );

    hsvd_div #(
        .NUM_W (hsvd_pkg::SNUM_W),
        .DEN_W (hsvd_pkg::SDEN_W),
        .QUO_W (NS)
    ) u_sdiv (
        .clk (clk),
        .en  (adv),
        .num (s_num),
        .den (s_den),
        .quo (s_quo)
    );

    // sideband travels alongside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= '{v: v_b_reg, d_zero: (d_b_reg == 8'd0), frame_end: fe_b_reg};
            for (int i = 1; i < NS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // final hue rotation and window tests; no spread gives H = S = 0
    always_comb
    begin
        val = side_reg[NS-1].v;
        if (side_reg[NS-1].d_zero)
        begin
            hue = 8'd0;
            sat = 8'd0;
        end
        else
        begin
            hue = (h_quo >= hsvd_pkg::HUE_OFFSET) ? h_quo - hsvd_pkg::HUE_OFFSET
                                                  : h_quo + hsvd_pkg::HUE_WRAP;
            sat = s_quo;
        end
        hits.frame_end = side_reg[NS-1].frame_end;
        hits.red   = (hue <= hsvd_pkg::RED_H_HI)
                  && (sat >= hsvd_pkg::RG_S_LO) && (val >= hsvd_pkg::RG_V_LO);
        hits.green = (hue >= hsvd_pkg::GREEN_H_LO) && (hue <= hsvd_pkg::GREEN_H_HI)
                  && (sat >= hsvd_pkg::RG_S_LO) && (val >= hsvd_pkg::RG_V_LO);
        hits.blue  = (hue >= hsvd_pkg::BLUE_H_LO) && (hue <= hsvd_pkg::BLUE_H_HI)
                  && (sat >= hsvd_pkg::BLUE_S_LO) && (val >= hsvd_pkg::BLUE_V_LO);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hits_c_reg <= hits;
        end
    end

    assign q_push = valid_c_reg && !q_full;
    assign q_data = hits_c_reg;

    // a blocked output stage keeps its transaction
    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg && q_full |=> valid_c_reg && $stable(hits_c_reg))
        else $error("front output stage lost a blocked transaction");

endmodule

`default_nettype wire

[rtl/hsvd_fifo.sv]
// hsvd_fifo: small flop-based queue between classification and counting.
// Uses no package items.
`default_nettype none

module hsvd_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  wr_full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  rd_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && !wr_full;
    assign do_rd = rd_en && !rd_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data  = mem_reg[rd_ptr_reg];
    assign rd_empty = (count_reg == '0);
    assign wr_full  = (count_reg == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a write");

endmodule

`default_nettype wire

[rtl/hsvd_back.sv]
// hsvd_back: hit counting, end-of-frame decision and result register.
// Depends on hsvd_pkg.
`default_nettype none

module hsvd_back #(
    parameter int COUNT_BITS = hsvd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [hsvd_pkg::THRESH_W-1:0] cfg_wdata,
    input  wire logic                          q_empty,
    input  wire hsvd_pkg::hit_t                q_data,
    output logic                               q_pop,
    input  wire logic                          pop,
    output logic                               empty,
    output hsvd_pkg::result_t                  result
);

    localparam int TW = hsvd_pkg::THRESH_W;
    localparam int PW = COUNT_BITS + TW;

    logic [TW-1:0] thr_reg;

    logic [COUNT_BITS-1:0] cnt_r_reg, cnt_g_reg, cnt_b_reg, cnt_p_reg;
    logic [COUNT_BITS-1:0] new_r, new_g, new_b, new_p;

    logic                  fin_valid_reg, fin_valid_next;
    logic [COUNT_BITS-1:0] fin_r_reg, fin_g_reg, fin_b_reg, fin_p_reg;

    logic                   out_valid_reg, out_valid_next;
    hsvd_pkg::result_t      res_reg;
    hsvd_pkg::color_class_t cls;

    logic out_room, out_load, fin_free, take;
    logic [PW-1:0] lim, sc_r, sc_g, sc_b;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // handshake between queue, decision stage and result register
    assign out_room = !out_valid_reg || pop;
    assign out_load = fin_valid_reg && out_room;
    assign fin_free = !fin_valid_reg || out_room;
    assign take     = !q_empty && (!q_data.frame_end || fin_free);
    assign q_pop    = take;

    assign new_r = q_data.red   ? sat_inc(cnt_r_reg) : cnt_r_reg;
    assign new_g = q_data.green ? sat_inc(cnt_g_reg) : cnt_g_reg;
    assign new_b = q_data.blue  ? sat_inc(cnt_b_reg) : cnt_b_reg;
    assign new_p = sat_inc(cnt_p_reg);

    assign fin_valid_next = (fin_valid_reg && !out_load) || (take && q_data.frame_end);
    assign out_valid_next = out_load || (out_valid_reg && !pop);

    // threshold register, counters and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= hsvd_pkg::THRESH_RESET;
            cnt_r_reg     <= '0;
            cnt_g_reg     <= '0;
            cnt_b_reg     <= '0;
            cnt_p_reg     <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (take)
            begin
                if (q_data.frame_end)
                begin
                    cnt_r_reg <= '0;
                    cnt_g_reg <= '0;
                    cnt_b_reg <= '0;
                    cnt_p_reg <= '0;
                end
                else
                begin
                    cnt_r_reg <= new_r;
                    cnt_g_reg <= new_g;
                    cnt_b_reg <= new_b;
                    cnt_p_reg <= new_p;
                end
            end
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // final counts of the frame, held for the decision
    always_ff @(posedge clk)
    begin
        if (take && q_data.frame_end)
        begin
            fin_r_reg <= new_r;
            fin_g_reg <= new_g;
            fin_b_reg <= new_b;
            fin_p_reg <= new_p;
        end
    end

    // 255*count against threshold*pixels, red first
    assign lim  = PW'(thr_reg) * PW'(fin_p_reg);
    assign sc_r = (PW'(fin_r_reg) << TW) - PW'(fin_r_reg);
    assign sc_g = (PW'(fin_g_reg) << TW) - PW'(fin_g_reg);
    assign sc_b = (PW'(fin_b_reg) << TW) - PW'(fin_b_reg);

    always_comb
    begin
        if (sc_r > lim)
        begin
            cls = hsvd_pkg::COLOR_RED;
        end
        else if (sc_g > lim)
        begin
            cls = hsvd_pkg::COLOR_GREEN;
        end
        else if (sc_b > lim)
        begin
            cls = hsvd_pkg::COLOR_BLUE;
        end
        else
        begin
            cls = hsvd_pkg::COLOR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg.color_class <= cls;
            res_reg.red_hits    <= hsvd_pkg::HIT_W'(fin_r_reg);
            res_reg.green_hits  <= hsvd_pkg::HIT_W'(fin_g_reg);
            res_reg.blue_hits   <= hsvd_pkg::HIT_W'(fin_b_reg);
        end
    end

    assign empty  = !out_valid_reg;
    assign result = res_reg;

    a_hits_le_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_r_reg <= cnt_p_reg && cnt_g_reg <= cnt_p_reg && cnt_b_reg <= cnt_p_reg)
        else $error("hit counter exceeds pixel counter");

    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_data.frame_end |=> cnt_p_reg == '0)
        else $error("counters not cleared after frame end");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !out_room |=> fin_valid_reg && $stable(fin_p_reg))
        else $error("pending frame decision overwritten");

endmodule

`default_nettype wire

[tb/hsvd_checker.sv]
// hsvd_checker: watches the pixel, result and config channels of the detector,
// predicts each frame result and compares it with what the block returns.
// Depends on hsvd_pkg for the payload types and field widths.
`timescale 1ns / 1ps

module hsvd_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                full,
    input  wire hsvd_pkg::pixel_t    pixel,
    input  wire logic                pop,
    input  wire logic                empty,
    input  wire hsvd_pkg::result_t   result,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata,
    output int                       fail_count,
    output int                       pending
);
    import hsvd_pkg::*;

    localparam int CNT_W = COUNT_BITS_DEF;
    localparam logic [7:0] DEFAULT_LEVEL = 8'd15;

    // Inclusive HSV windows
    localparam int unsigned RED_HUE_MAX   = 10;
    localparam int unsigned GREEN_HUE_MIN = 40;
    localparam int unsigned GREEN_HUE_MAX = 80;
    localparam int unsigned BLUE_HUE_MIN  = 85;
    localparam int unsigned BLUE_HUE_MAX  = 135;
    localparam int unsigned WARM_SAT_MIN  = 70;
    localparam int unsigned WARM_VAL_MIN  = 50;
    localparam int unsigned BLUE_SAT_MIN  = 50;
    localparam int unsigned BLUE_VAL_MIN  = 40;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } window_t;

    logic [7:0]       mean_level;
    logic [CNT_W-1:0] red_count;
    logic [CNT_W-1:0] green_count;
    logic [CNT_W-1:0] blue_count;
    logic [CNT_W-1:0] pixel_count;
    result_t          expected_frames[$];
    int               mismatches;

    // RGB to 8-bit HSV, then test against the three windows
    function automatic window_t classify_pixel(input pixel_t px);
        int unsigned r, g, b, v, lo, d, sector, hue, sat;
        window_t hit;
        r = px.red;
        g = px.green;
        b = px.blue;
        v = r;
        lo = r;
        if (g > v) v = g;
        if (b > v) v = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d = v - lo;
        sat = (v == 0) ? 0 : (255 * d + v / 2) / v;
        hue = 0;
        if (d != 0)
        begin
            // ties on the maximum go to red, then green
            if (v == r)
                sector = g + d - b;
            else if (v == g)
                sector = b + 3 * d - r;
            else
                sector = r + 5 * d - g;
            hue = (60 * sector + d) / (2 * d);
            hue = (hue >= 30) ? hue - 30 : hue + 150;
        end
        hit.red   = hue <= RED_HUE_MAX && sat >= WARM_SAT_MIN && v >= WARM_VAL_MIN;
        hit.green = hue >= GREEN_HUE_MIN && hue <= GREEN_HUE_MAX &&
                    sat >= WARM_SAT_MIN && v >= WARM_VAL_MIN;
        hit.blue  = hue >= BLUE_HUE_MIN && hue <= BLUE_HUE_MAX &&
                    sat >= BLUE_SAT_MIN && v >= BLUE_VAL_MIN;
        return hit;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t           want;
        window_t           hit;
        longint unsigned   level;
        color_class_t      winner;
        if (!rst_n)
        begin
            mean_level  = DEFAULT_LEVEL;
            red_count   = '0;
            green_count = '0;
            blue_count  = '0;
            pixel_count = '0;
            expected_frames.delete();
            mismatches  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
                mean_level = cfg_wdata;

            // result transaction: compare with the oldest expected frame
            if (pop && !empty)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: result with none expected, actual class %0d hits %0d/%0d/%0d",
                             $time, result.color_class, result.red_hits,
                             result.green_hits, result.blue_hits);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("color_class", want.color_class, result.color_class);
                    check_field("red_hits", want.red_hits, result.red_hits);
                    check_field("green_hits", want.green_hits, result.green_hits);
                    check_field("blue_hits", want.blue_hits, result.blue_hits);
                end
            end

            // pixel transaction: count, and decide on the frame's last pixel
            if (push && !full)
            begin
                hit = classify_pixel(pixel);
                if (hit.red) red_count = bump(red_count);
                if (hit.green) green_count = bump(green_count);
                if (hit.blue) blue_count = bump(blue_count);
                pixel_count = bump(pixel_count);
                if (pixel.frame_end)
                begin
                    level = longint'(mean_level) * pixel_count;
                    if (64'd255 * red_count > level)
                        winner = COLOR_RED;
                    else if (64'd255 * green_count > level)
                        winner = COLOR_GREEN;
                    else if (64'd255 * blue_count > level)
                        winner = COLOR_BLUE;
                    else
                        winner = COLOR_NONE;
                    want.color_class = winner;
                    want.red_hits    = HIT_W'(red_count);
                    want.green_hits  = HIT_W'(green_count);
                    want.blue_hits   = HIT_W'(blue_count);
                    expected_frames.push_back(want);
                    red_count   = '0;
                    green_count = '0;
                    blue_count  = '0;
                    pixel_count = '0;
                end
            end

            pending    <= expected_frames.size();
            fail_count <= mismatches;
        end
    end

endmodule

[tb/hsv_dominant_color_detect_test.sv]
// hsv_dominant_color_detect_test: top of the detector testbench; drives pixel
// frames and threshold writes, stalls the result side, and gives the verdict.
// Depends on hsvd_pkg, hsv_dominant_color_detect and hsvd_checker.
`timescale 1ns / 1ps

module hsv_dominant_color_detect_test;
    import hsvd_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 125;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          push;
    logic          full;
    pixel_t        pixel;
    logic          pop;
    logic          empty;
    result_t       result;
    logic          cfg_we;
    logic [7:0]    cfg_wdata;
    int            fail_count;
    int            pending;
    bit            steady;
    int            quiet_cycles;

    hsv_dominant_color_detect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hsvd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .pop        (pop),
        .empty      (empty),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: pop low about one cycle in ten, never while steady
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            pop <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && !full) || (pop && !empty) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One pixel transaction, with an occasional idle cycle ahead of it when not steady
    task automatic send_pixel(input pixel_t px);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
        pixel_t px;
        px.red       = r;
        px.green     = g;
        px.blue      = b;
        px.frame_end = last;
        send_pixel(px);
    endtask

    // Threshold write once every frame result has drained
    task automatic set_threshold(input logic [7:0] level);
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Pixel leaning to one channel; COLOR_NONE gives a uniform random pixel
    function automatic pixel_t tinted_pixel(input color_class_t tint);
        pixel_t px;
        logic [7:0] peak, c1, c2;
        peak = 8'($urandom_range(30, 255));
        c1   = 8'($urandom_range(0, peak / 2));
        c2   = 8'($urandom_range(0, peak / 2));
        case (tint)
            COLOR_RED:   px = {peak, c1, c2, 1'b0};
            COLOR_GREEN: px = {c1, peak, c2, 1'b0};
            COLOR_BLUE:  px = {c1, c2, peak, 1'b0};
            default:     px = {8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
        endcase
        return px;
    endfunction

    // Whole frames with a random tint until the item budget is used up
    task automatic send_frames(input int budget);
        int sent;
        int len;
        color_class_t tint;
        pixel_t px;
        sent = 0;
        while (sent < budget)
        begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
            tint = color_class_t'($urandom_range(0, 3));
            for (int i = 0; i < len; i++)
            begin
                px = ($urandom_range(0, 99) < 65) ? tinted_pixel(tint)
                                                  : tinted_pixel(COLOR_NONE);
                px.frame_end = (i == len - 1);
                send_pixel(px);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pixel     = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        steady    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset threshold
        send_rgb(8'd255, 8'd0, 8'd0, 1'b1);        // single pixel frame, pure red
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);          // black
        send_rgb(8'd255, 8'd255, 8'd255, 1'b0);    // white, no hue spread
        send_rgb(8'd0, 8'd255, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd0, 1'b1);
        send_rgb(8'd0, 8'd0, 8'd255, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd255, 1'b0);      // tie green/blue, green holds V
        send_rgb(8'd255, 8'd255, 8'd0, 1'b0);      // tie red/green, red holds V
        send_rgb(8'd255, 8'd0, 8'd255, 1'b1);      // tie red/blue, red holds V
        send_rgb(8'd49, 8'd0, 8'd0, 1'b0);         // value just under the red window
        send_rgb(8'd50, 8'd0, 8'd0, 1'b0);         // value on its edge
        send_rgb(8'd1, 8'd1, 8'd2, 1'b0);
        send_rgb(8'd128, 8'd128, 8'd128, 1'b1);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);          // frame with no color
        send_rgb(8'd255, 8'd255, 8'd255, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd0, 1'b1);
        send_rgb(8'd255, 8'd186, 8'd186, 1'b0);    // saturation just under 70
        send_rgb(8'd255, 8'd185, 8'd185, 1'b1);    // saturation exactly 70
        send_rgb(8'd170, 8'd85, 8'd254, 1'b0);
        send_rgb(8'd85, 8'd170, 8'd1, 1'b1);

        // Random frames across threshold settings, extremes included
        set_threshold(8'd0);
        send_frames(PHASE_ITEMS);
        set_threshold(8'd255);
        send_frames(PHASE_ITEMS);
        set_threshold(8'($urandom_range(1, 254)));
        steady = 1'b1;
        send_frames(PHASE_ITEMS);
        steady = 1'b0;
        set_threshold(8'd1);
        send_frames(PHASE_ITEMS);
        set_threshold(8'($urandom_range(2, 128)));
        send_frames(PHASE_ITEMS);

        // Drain and verdict
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/hsvd_pkg.sv
rtl/hsvd_div.sv
rtl/hsvd_front.sv
rtl/hsvd_fifo.sv
rtl/hsvd_back.sv
rtl/hsv_dominant_color_detect.sv
tb/hsvd_checker.sv
tb/hsv_dominant_color_detect_test.sv
